### src/i2c_eeprom_access_sequencer_defines.svh
// ----------------------------------------------------------------------------
// I2C EEPROM access sequencer - assertion macros
// Shared macros for concurrent checks; build with NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef I2C_EEPROM_ACCESS_SEQUENCER_DEFINES_SVH
`define I2C_EEPROM_ACCESS_SEQUENCER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// check on every edge outside reset
`define I2CEA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check on every edge, reset included
`define I2CEA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define I2CEA_ASSERT(lbl, prop, msg)
`define I2CEA_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### src/i2cea_pkg.sv
// ----------------------------------------------------------------------------
// i2cea_pkg
// Types, codes and constants shared by the I2C EEPROM access sequencer.
// ----------------------------------------------------------------------------
package i2cea_pkg;

  localparam int MAX_BYTES_DFLT = 4;
  // width that holds any byte_count value and any MAX_BYTES (up to 15)
  localparam int CNT_CMP_W      = 4;

  localparam logic [7:0] WR_CTRL_RST = 8'd160;
  localparam logic [7:0] RD_CTRL_RST = 8'd161;

  // action codes
  localparam logic [1:0] ACT_WRITE    = 2'd0;
  localparam logic [1:0] ACT_READ     = 2'd1;
  localparam logic [1:0] ACT_COMPLETE = 2'd2;

  // bus command codes
  localparam logic [2:0] CMD_START = 3'd0;
  localparam logic [2:0] CMD_SEND  = 3'd1;
  localparam logic [2:0] CMD_RECV  = 3'd2;
  localparam logic [2:0] CMD_NACK  = 3'd3;
  localparam logic [2:0] CMD_STOP  = 3'd4;
  localparam logic [2:0] CMD_DONE  = 3'd5;

  // configuration register indexes
  localparam logic CFG_WR_CTRL = 1'b0;
  localparam logic CFG_RD_CTRL = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] address;
    logic [2:0]  byte_count;
    logic [31:0] write_data;
    logic        ack;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  tx_byte;
    logic [31:0] read_data;
    logic        last;
  } result_t;

endpackage

### src/i2c_eeprom_access_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_access_sequencer
// Sequences byte-level I2C master commands for 16-bit-addressed EEPROM access.
// ----------------------------------------------------------------------------
// Each input beat is either a read/write request (start address, 1 to
// MAX_BYTES bytes, write data) or the completion of the bus command issued
// last (with its ack bit and received byte). Each beat that matters answers
// with one command beat for the bus controller: start, send, receive,
// not-acknowledge, stop, or a final "request complete" beat flagged by
// out_tlast and carrying all bytes read. Every byte is its own transaction
// (start, write control, address high, address low, then a data byte or a
// repeated start, read control, receive and not-acknowledge, then stop), the
// most significant data byte first at the lowest address; a control byte
// with no acknowledge is retried from a new start. Requests while busy and
// completions while idle are dropped silently. The block takes one beat per
// clock cycle sustained while the output drains: a beat is captured in an
// input register, its phase step is done in one pass through the phase
// logic, and its result lands in an output register once that one is free.
// A stalled output holds both stages; the input register keeps taking beats
// as long as the output register drains. The user must write the control
// byte registers through the cfg port only while the block is idle; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module i2c_eeprom_access_sequencer #(
  parameter int MAX_BYTES = i2cea_pkg::MAX_BYTES_DFLT
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: 0 write control byte, 1 read control byte
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] address, [18:16] byte_count, [50:19] write_data, [51] ack,
  // [59:52] rx_byte, [63:60] zero
  input  logic [63:0] in_tdata,
  // [1:0] action
  input  logic [1:0]  in_tuser,
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] tx_byte, [39:8] read_data
  output logic [39:0] out_tdata,
  // [2:0] command
  output logic [2:0]  out_tuser,
  output logic        out_tlast
);

  i2cea_pkg::item_t   in_item;
  i2cea_pkg::item_t   item;
  i2cea_pkg::result_t res;
  i2cea_pkg::result_t out_res;
  logic               item_valid;
  logic               out_free;
  logic               advance;
  logic               res_valid;

  // unpack the input beat
  assign in_item.action     = in_tuser;
  assign in_item.address    = in_tdata[15:0];
  assign in_item.byte_count = in_tdata[18:16];
  assign in_item.write_data = in_tdata[50:19];
  assign in_item.ack        = in_tdata[51];
  assign in_item.rx_byte    = in_tdata[59:52];

  // advance the held beat through the phase logic when the result slot frees
  assign advance = item_valid && out_free;

  i2cea_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .out_free   (out_free),
    .item_valid (item_valid),
    .item       (item)
  );

  i2cea_seq_core #(
    .MAX_BYTES (MAX_BYTES)
  ) u_seq_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (advance),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  i2cea_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // pack the result beat
  assign out_tdata = {out_res.read_data, out_res.tx_byte};
  assign out_tuser = out_res.command;
  assign out_tlast = out_res.last;

endmodule

### src/i2cea_in_stage.sv
// ----------------------------------------------------------------------------
// i2cea_in_stage
// Input register: captures one beat and hands it to the sequencer core.
// ----------------------------------------------------------------------------
module i2cea_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  i2cea_pkg::item_t  in_item,
  input  logic              out_free,
  output logic              item_valid,
  output i2cea_pkg::item_t  item
);

  logic             vld_r, vld_nxt;
  i2cea_pkg::item_t item_r;

  // take a new beat when empty or when the held one moves on this cycle
  assign in_ready = !vld_r || out_free;

  always_comb begin
    vld_nxt = vld_r;
    if (in_ready) begin
      vld_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = vld_r;
  assign item       = item_r;

endmodule

### src/i2cea_seq_core.sv
// ----------------------------------------------------------------------------
// i2cea_seq_core
// Transaction phase machine, request state and control byte registers.
// ----------------------------------------------------------------------------
`include "i2c_eeprom_access_sequencer_defines.svh"

module i2cea_seq_core #(
  parameter int MAX_BYTES = i2cea_pkg::MAX_BYTES_DFLT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               advance,
  input  i2cea_pkg::item_t   item,
  output logic               res_valid,
  output i2cea_pkg::result_t res
);

  localparam int CNT_W = $clog2(MAX_BYTES + 1);
  localparam int CW    = i2cea_pkg::CNT_CMP_W;

  typedef enum logic [10:0] {
    PH_IDLE   = 11'b000_0000_0001,
    PH_START  = 11'b000_0000_0010,
    PH_CTRL_W = 11'b000_0000_0100,
    PH_ADDR_H = 11'b000_0000_1000,
    PH_ADDR_L = 11'b000_0001_0000,
    PH_DATA   = 11'b000_0010_0000,
    PH_RSTART = 11'b000_0100_0000,
    PH_CTRL_R = 11'b000_1000_0000,
    PH_RECV   = 11'b001_0000_0000,
    PH_NACK   = 11'b010_0000_0000,
    PH_STOP   = 11'b100_0000_0000
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic             is_read_r, is_read_nxt;
  logic [15:0]      addr_r, addr_nxt;
  logic [31:0]      data_word_r, data_word_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic [31:0]      read_word_r, read_word_nxt;
  logic [7:0]       wr_ctrl_r, rd_ctrl_r;

  logic             is_req;
  logic [CW-1:0]    count_sat;
  logic [CW-1:0]    byte_sel;
  logic [7:0]       data_byte;
  logic [CNT_W-1:0] left_dec;

  // assertion helpers
  logic             busy;
  logic             done_step;
  logic             req_step;
  logic             idle_cmpl;

  assign is_req = (item.action == i2cea_pkg::ACT_WRITE) ||
                  (item.action == i2cea_pkg::ACT_READ);

  // clamp the requested count into 1..MAX_BYTES
  always_comb begin
    count_sat = CW'(item.byte_count);
    if (item.byte_count == 3'd0) begin
      count_sat = CW'(1);
    end else if (CW'(item.byte_count) > CW'(MAX_BYTES)) begin
      count_sat = CW'(MAX_BYTES);
    end
  end

  // data byte for the current transfer, most significant first; zero past bit 31
  assign byte_sel = CW'(left_r) - CW'(1);
  always_comb begin
    data_byte = 8'd0;
    if (left_r != '0 && byte_sel < CW'(4)) begin
      data_byte = data_word_r[8*byte_sel[1:0] +: 8];
    end
  end

  assign left_dec = (left_r != '0) ? left_r - CNT_W'(1) : left_r;

  always_comb begin
    phase_nxt     = phase_r;
    is_read_nxt   = is_read_r;
    addr_nxt      = addr_r;
    data_word_nxt = data_word_r;
    left_nxt      = left_r;
    read_word_nxt = read_word_r;
    res_valid     = 1'b0;
    res.command   = i2cea_pkg::CMD_START;
    res.tx_byte   = 8'd0;
    res.last      = 1'b0;

    if (is_req) begin
      if (phase_r == PH_IDLE) begin
        is_read_nxt   = (item.action == i2cea_pkg::ACT_READ);
        addr_nxt      = item.address;
        data_word_nxt = item.write_data;
        left_nxt      = CNT_W'(count_sat);
        read_word_nxt = 32'd0;
        phase_nxt     = PH_START;
        res_valid     = 1'b1;
      end
    end else if (item.action == i2cea_pkg::ACT_COMPLETE && phase_r != PH_IDLE) begin
      res_valid = 1'b1;
      unique case (phase_r)
        PH_START: begin
          phase_nxt   = PH_CTRL_W;
          res.command = i2cea_pkg::CMD_SEND;
          res.tx_byte = wr_ctrl_r;
        end
        PH_CTRL_W: begin
          if (item.ack) begin
            phase_nxt   = PH_ADDR_H;
            res.command = i2cea_pkg::CMD_SEND;
            res.tx_byte = addr_r[15:8];
          end else begin
            phase_nxt   = PH_START;
          end
        end
        PH_ADDR_H: begin
          phase_nxt   = PH_ADDR_L;
          res.command = i2cea_pkg::CMD_SEND;
          res.tx_byte = addr_r[7:0];
        end
        PH_ADDR_L: begin
          if (is_read_r) begin
            phase_nxt   = PH_RSTART;
          end else begin
            phase_nxt   = PH_DATA;
            res.command = i2cea_pkg::CMD_SEND;
            res.tx_byte = data_byte;
          end
        end
        PH_DATA: begin
          phase_nxt   = PH_STOP;
          res.command = i2cea_pkg::CMD_STOP;
        end
        PH_RSTART: begin
          phase_nxt   = PH_CTRL_R;
          res.command = i2cea_pkg::CMD_SEND;
          res.tx_byte = rd_ctrl_r;
        end
        PH_CTRL_R: begin
          if (item.ack) begin
            phase_nxt   = PH_RECV;
            res.command = i2cea_pkg::CMD_RECV;
          end else begin
            phase_nxt   = PH_RSTART;
          end
        end
        PH_RECV: begin
          read_word_nxt = {read_word_r[23:0], item.rx_byte};
          phase_nxt     = PH_NACK;
          res.command   = i2cea_pkg::CMD_NACK;
        end
        PH_NACK: begin
          phase_nxt   = PH_STOP;
          res.command = i2cea_pkg::CMD_STOP;
        end
        PH_STOP: begin
          left_nxt = left_dec;
          addr_nxt = addr_r + 16'd1;
          if (left_dec == '0) begin
            phase_nxt   = PH_IDLE;
            res.command = i2cea_pkg::CMD_DONE;
            res.last    = 1'b1;
          end else begin
            phase_nxt   = PH_START;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          res_valid = 1'b0;
        end
      endcase
    end

    res.read_data = read_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      is_read_r   <= 1'b0;
      addr_r      <= 16'd0;
      data_word_r <= 32'd0;
      left_r      <= '0;
      read_word_r <= 32'd0;
    end else if (advance) begin
      phase_r     <= phase_nxt;
      is_read_r   <= is_read_nxt;
      addr_r      <= addr_nxt;
      data_word_r <= data_word_nxt;
      left_r      <= left_nxt;
      read_word_r <= read_word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ctrl_r <= i2cea_pkg::WR_CTRL_RST;
      rd_ctrl_r <= i2cea_pkg::RD_CTRL_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == i2cea_pkg::CFG_WR_CTRL) begin
        wr_ctrl_r <= cfg_data;
      end else begin
        rd_ctrl_r <= cfg_data;
      end
    end
  end

  assign busy      = (phase_r != PH_IDLE);
  assign done_step = advance && res_valid && (res.command == i2cea_pkg::CMD_DONE);
  assign req_step  = advance && is_req && (phase_r == PH_IDLE);
  assign idle_cmpl = advance && !is_req && (phase_r == PH_IDLE);

  // a busy sequencer always has at least one byte still to move
  `I2CEA_ASSERT(a_busy_has_bytes, busy |-> (left_r != '0), "busy with no bytes left")
  // a completion result returns the machine to idle
  `I2CEA_ASSERT(a_done_to_idle, done_step |=> (phase_r == PH_IDLE), "done without idle")
  // an idle request opens a transaction with a cleared read word
  `I2CEA_ASSERT(a_req_opens, req_step |=> (phase_r == PH_START && read_word_r == '0), "open failed")
  // a bus completion while idle leaves the state untouched
  `I2CEA_ASSERT(a_idle_quiet, idle_cmpl |=> (phase_r == PH_IDLE && $stable(addr_r)), "idle changed")

endmodule

### src/i2cea_out_stage.sv
// ----------------------------------------------------------------------------
// i2cea_out_stage
// Result register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module i2cea_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  logic               res_valid,
  input  i2cea_pkg::result_t res,
  output logic               out_free,
  output logic               out_valid,
  input  logic               out_ready,
  output i2cea_pkg::result_t out_res
);

  logic               vld_r, vld_nxt;
  i2cea_pkg::result_t res_r;

  assign out_free = !vld_r || out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (advance) begin
      vld_nxt = res_valid;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

### bench/i2c_eeprom_access_sequencer_tb.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_access_sequencer_tb
// Self-checking bench for the I2C EEPROM access sequencer. A directed table
// walks the corner cases of one write and one read request. Random bus
// traffic follows: requests, completions, noise and both control-byte
// retries, under several idle patterns and control-byte settings. Every
// command beat is checked against a bench-side model of the sequencer.
// ----------------------------------------------------------------------------
module i2c_eeprom_access_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         MAX_BYTES   = i2cea_pkg::MAX_BYTES_DFLT;
  // action code the block has no use for
  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam int         LONG_HOLD   = 250;      // receiver back-pressure, cycles
  localparam int         SETTLE      = 8;        // covers the two-stage pipeline
  localparam int         ROUND_BEATS = 260;      // command beats per random round
  localparam int         RUN_LIMIT   = 5_000_000; // ns

  // --------------------------------------------------------------------------
  // DUT connections, all inputs known from time zero
  // --------------------------------------------------------------------------
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_wr_en  = 1'b0;
  logic        cfg_index  = i2cea_pkg::CFG_WR_CTRL;
  logic [7:0]  cfg_data   = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  // [15:0] address, [18:16] byte_count, [50:19] write_data, [51] ack,
  // [59:52] rx_byte, [63:60] zero
  logic [63:0] in_tdata   = '0;
  // [1:0] action
  logic [1:0]  in_tuser   = i2cea_pkg::ACT_WRITE;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [7:0] tx_byte, [39:8] read_data
  logic [39:0] out_tdata;
  // [2:0] command
  logic [2:0]  out_tuser;
  logic        out_tlast;

  i2c_eeprom_access_sequencer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Sequencer model: phase, request context and control-byte registers
  // --------------------------------------------------------------------------
  typedef enum logic [3:0] {
    ST_IDLE, ST_START, ST_CTRL_W, ST_ADDR_H, ST_ADDR_L, ST_DATA,
    ST_RSTART, ST_CTRL_R, ST_RECV, ST_NACK, ST_STOP
  } seq_state_t;

  seq_state_t  ph       = ST_IDLE;
  bit          rd_mode  = 1'b0;
  logic [15:0] cur_addr = '0;
  logic [31:0] wr_word  = '0;
  logic [2:0]  left     = '0;
  logic [31:0] rd_word  = '0;
  logic [7:0]  wr_ctrl  = i2cea_pkg::WR_CTRL_RST;
  logic [7:0]  rd_ctrl  = i2cea_pkg::RD_CTRL_RST;

  // Advance the model by one accepted beat; return 1 when a command is due.
  function automatic bit seq_step(input i2cea_pkg::item_t b,
                                  output i2cea_pkg::result_t r);
    int n;
    r = '0;
    if (b.action == i2cea_pkg::ACT_WRITE || b.action == i2cea_pkg::ACT_READ) begin
      // a request while a transfer runs is dropped
      if (ph != ST_IDLE) return 1'b0;
      // count zero means one byte, anything above the maximum saturates
      n = (b.byte_count == 3'd0) ? 1 : int'(b.byte_count);
      if (n > MAX_BYTES) n = MAX_BYTES;
      rd_mode   = (b.action == i2cea_pkg::ACT_READ);
      cur_addr  = b.address;
      wr_word   = b.write_data;
      left      = 3'(n);
      rd_word   = '0;
      ph        = ST_START;
      r.command = i2cea_pkg::CMD_START;
      r.read_data = rd_word;
      return 1'b1;
    end
    // completions while idle and the spare action code are dropped
    if (b.action != i2cea_pkg::ACT_COMPLETE || ph == ST_IDLE) return 1'b0;
    case (ph)
      ST_START: begin
        ph = ST_CTRL_W;
        r.command = i2cea_pkg::CMD_SEND;
        r.tx_byte = wr_ctrl;
      end
      ST_CTRL_W: begin
        // no ack on the control byte: retry from a fresh start
        if (b.ack) begin
          ph = ST_ADDR_H;
          r.command = i2cea_pkg::CMD_SEND;
          r.tx_byte = cur_addr[15:8];
        end else begin
          ph = ST_START;
          r.command = i2cea_pkg::CMD_START;
        end
      end
      ST_ADDR_H: begin
        ph = ST_ADDR_L;
        r.command = i2cea_pkg::CMD_SEND;
        r.tx_byte = cur_addr[7:0];
      end
      ST_ADDR_L: begin
        if (rd_mode) begin
          ph = ST_RSTART;
          r.command = i2cea_pkg::CMD_START;
        end else begin
          // most significant remaining byte goes first
          ph = ST_DATA;
          r.command = i2cea_pkg::CMD_SEND;
          r.tx_byte = 8'(wr_word >> (8 * (int'(left) - 1)));
        end
      end
      ST_DATA: begin
        ph = ST_STOP;
        r.command = i2cea_pkg::CMD_STOP;
      end
      ST_RSTART: begin
        ph = ST_CTRL_R;
        r.command = i2cea_pkg::CMD_SEND;
        r.tx_byte = rd_ctrl;
      end
      ST_CTRL_R: begin
        if (b.ack) begin
          ph = ST_RECV;
          r.command = i2cea_pkg::CMD_RECV;
        end else begin
          ph = ST_RSTART;
          r.command = i2cea_pkg::CMD_START;
        end
      end
      ST_RECV: begin
        rd_word = {rd_word[23:0], b.rx_byte};
        ph = ST_NACK;
        r.command = i2cea_pkg::CMD_NACK;
      end
      ST_NACK: begin
        ph = ST_STOP;
        r.command = i2cea_pkg::CMD_STOP;
      end
      ST_STOP: begin
        if (left != 3'd0) left = left - 3'd1;
        cur_addr = cur_addr + 16'd1;   // wraps at 16 bits
        if (left == 3'd0) begin
          ph = ST_IDLE;
          r.command = i2cea_pkg::CMD_DONE;
          r.last = 1'b1;
        end else begin
          ph = ST_START;
          r.command = i2cea_pkg::CMD_START;
        end
      end
      default: begin
        ph = ST_IDLE;
        return 1'b0;
      end
    endcase
    r.read_data = rd_word;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Expected command beats, oldest first
  // --------------------------------------------------------------------------
  i2cea_pkg::result_t cmd_expected[$];
  int                 err_cnt = 0;

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;

  // long receiver stall: the driver bumps the request count, the receiver
  // counts the stall down on its own
  int hold_req_cnt = 0;
  int hold_seen    = 0;
  int hold_left    = 0;

  // --------------------------------------------------------------------------
  // Receiver: check each command beat, then pick next cycle's tready
  // --------------------------------------------------------------------------
  function automatic void check_cmd_beat();
    i2cea_pkg::result_t w;
    if (cmd_expected.size() == 0) begin
      $error("unexpected command beat: command %0d tx_byte %0h read_data %0h last %0b",
             out_tuser, out_tdata[7:0], out_tdata[39:8], out_tlast);
      err_cnt++;
      return;
    end
    w = cmd_expected.pop_front();
    if (out_tuser !== w.command) begin
      $error("command: expected %0d, got %0d", w.command, out_tuser);
      err_cnt++;
    end
    if (out_tdata[7:0] !== w.tx_byte) begin
      $error("tx_byte: expected %0h, got %0h", w.tx_byte, out_tdata[7:0]);
      err_cnt++;
    end
    if (out_tdata[39:8] !== w.read_data) begin
      $error("read_data: expected %0h, got %0h", w.read_data, out_tdata[39:8]);
      err_cnt++;
    end
    if (out_tlast !== w.last) begin
      $error("last: expected %0b, got %0b", w.last, out_tlast);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_cmd_beat();
    if (hold_seen != hold_req_cnt) begin
      hold_seen = hold_req_cnt;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Sender helpers
  // --------------------------------------------------------------------------
  // Offer one beat, hold it until accepted, then log what it should cause.
  // A typed row replaces the model's answer with the one written in the table.
  task automatic send_beat(input i2cea_pkg::item_t b, input bit typed, input bit yields,
                           input i2cea_pkg::result_t want, output bit produced);
    i2cea_pkg::result_t r;
    bit                 got;
    // idle the sender cycle by cycle before offering
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= b.action;
    in_tdata  <= {4'b0, b.rx_byte, b.ack, b.write_data, b.byte_count, b.address};
    do @(posedge clk); while (!in_tready);
    got = seq_step(b, r);
    if (typed) begin
      got = yields;
      r   = want;
    end
    if (got) cmd_expected.push_back(r);
    produced = got;
  endtask

  // Stop offering and wait until every command beat has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (cmd_expected.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write both control-byte registers on back-to-back edges.
  task automatic program_ctrl(input logic [7:0] wr, input logic [7:0] rd);
    cfg_wr_en <= 1'b1;
    cfg_index <= i2cea_pkg::CFG_WR_CTRL;
    cfg_data  <= wr;
    @(posedge clk);
    wr_ctrl   = wr;
    cfg_index <= i2cea_pkg::CFG_RD_CTRL;
    cfg_data  <= rd;
    @(posedge clk);
    rd_ctrl   = rd;
    cfg_wr_en <= 1'b0;
  endtask

  // Random beat shaped by the model's phase: mostly well-formed traffic,
  // with stray requests, stray completions and the spare action code mixed in.
  function automatic i2cea_pkg::item_t next_beat();
    i2cea_pkg::item_t b;
    int               pick;
    b.address = 16'($urandom);
    if ($urandom_range(15) == 0) b.address = 16'hFFFC + 16'($urandom_range(3));
    b.byte_count = ($urandom_range(9) < 8) ? 3'($urandom_range(4, 1))
                                           : 3'($urandom_range(7));
    b.write_data = $urandom;
    b.ack        = ($urandom_range(99) < 85);
    b.rx_byte    = 8'($urandom);
    pick = $urandom_range(99);
    if (ph == ST_IDLE) begin
      if (pick < 85)      b.action = $urandom_range(1) ? i2cea_pkg::ACT_READ
                                                       : i2cea_pkg::ACT_WRITE;
      else if (pick < 93) b.action = i2cea_pkg::ACT_COMPLETE;
      else                b.action = ACT_UNUSED;
    end else begin
      if (pick < 88)      b.action = i2cea_pkg::ACT_COMPLETE;
      else if (pick < 94) b.action = $urandom_range(1) ? i2cea_pkg::ACT_READ
                                                       : i2cea_pkg::ACT_WRITE;
      else                b.action = ACT_UNUSED;
    end
    return b;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  typedef struct {
    i2cea_pkg::item_t   beat;
    bit                 typed;    // expectation written in the row
    bit                 yields;   // typed row: a command beat is due
    i2cea_pkg::result_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic i2cea_pkg::item_t mk_beat(logic [1:0] act, logic [15:0] addr,
                                               logic [2:0] cnt, logic [31:0] wdata,
                                               logic ack, logic [7:0] rx);
    i2cea_pkg::item_t b;
    b.action = act;
    b.address = addr;
    b.byte_count = cnt;
    b.write_data = wdata;
    b.ack = ack;
    b.rx_byte = rx;
    return b;
  endfunction

  function automatic i2cea_pkg::result_t mk_cmd(logic [2:0] cmd, logic [7:0] tx,
                                                logic [31:0] rd, logic lst);
    i2cea_pkg::result_t r;
    r.command = cmd;
    r.tx_byte = tx;
    r.read_data = rd;
    r.last = lst;
    return r;
  endfunction

  function automatic void add_row(i2cea_pkg::item_t b, bit typed, bit yields,
                                  i2cea_pkg::result_t w);
    dir_row_t row;
    row.beat = b;
    row.typed = typed;
    row.yields = yields;
    row.want = w;
    dir_rows.push_back(row);
  endfunction

  function automatic void build_table();
    i2cea_pkg::item_t c0, c1;
    c0 = mk_beat(i2cea_pkg::ACT_COMPLETE, '0, 3'd1, '0, 1'b0, 8'h00);
    c1 = mk_beat(i2cea_pkg::ACT_COMPLETE, '0, 3'd1, '0, 1'b1, 8'h00);
    // stray completion and spare action code while idle
    add_row(c1, 1, 0, '0);
    add_row(mk_beat(ACT_UNUSED, '0, 3'd1, '0, 1'b1, 8'h00), 1, 0, '0);
    // write at the top address, count zero runs as one byte
    add_row(mk_beat(i2cea_pkg::ACT_WRITE, 16'hFFFF, 3'd0, 32'hFFFF_FFFF, 1'b0, 8'h00),
            1, 1, mk_cmd(i2cea_pkg::CMD_START, 8'h00, '0, 1'b0));
    // request and spare code while busy
    add_row(mk_beat(i2cea_pkg::ACT_READ, 16'h1234, 3'd4, '0, 1'b1, 8'h00), 1, 0, '0);
    add_row(mk_beat(ACT_UNUSED, '0, 3'd1, '0, 1'b1, 8'h00), 1, 0, '0);
    add_row(c0, 1, 1, mk_cmd(i2cea_pkg::CMD_SEND, i2cea_pkg::WR_CTRL_RST, '0, 1'b0));
    // control byte not acknowledged: start over
    add_row(c0, 1, 1, mk_cmd(i2cea_pkg::CMD_START, 8'h00, '0, 1'b0));
    add_row(c1, 0, 0, '0);
    add_row(c1, 1, 1, mk_cmd(i2cea_pkg::CMD_SEND, 8'hFF, '0, 1'b0));
    // address acks are don't-care
    add_row(c0, 1, 1, mk_cmd(i2cea_pkg::CMD_SEND, 8'hFF, '0, 1'b0));
    add_row(c0, 1, 1, mk_cmd(i2cea_pkg::CMD_SEND, 8'hFF, '0, 1'b0));
    add_row(c1, 0, 0, '0);
    add_row(c1, 1, 1, mk_cmd(i2cea_pkg::CMD_DONE, 8'h00, '0, 1'b1));
    add_row(c1, 0, 0, '0);
    // read at the top address, count seven saturates; the second byte wraps
    add_row(mk_beat(i2cea_pkg::ACT_READ, 16'hFFFF, 3'd7, 32'h0, 1'b1, 8'h00), 0, 0, '0);
    add_row(c1, 0, 0, '0);
    add_row(c1, 0, 0, '0);
    add_row(c1, 0, 0, '0);
    add_row(c1, 0, 0, '0);
    add_row(c1, 1, 1, mk_cmd(i2cea_pkg::CMD_SEND, i2cea_pkg::RD_CTRL_RST, '0, 1'b0));
    // read control byte not acknowledged: repeated start again
    add_row(c0, 0, 0, '0);
    add_row(c1, 0, 0, '0);
    add_row(c1, 0, 0, '0);
    add_row(mk_beat(i2cea_pkg::ACT_COMPLETE, '0, 3'd1, '0, 1'b1, 8'hFF), 1, 1,
            mk_cmd(i2cea_pkg::CMD_NACK, 8'h00, 32'h0000_00FF, 1'b0));
    add_row(c1, 0, 0, '0);
    add_row(c1, 0, 0, '0);
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    i2cea_pkg::item_t b;
    bit               produced;
    int               done_cnt;
    int               beat_idx;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender mostly busy, receiver mostly stalled
    snd_idle_pct = 7;
    rcv_idle_pct = 63;
    build_table();
    foreach (dir_rows[i])
      send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].yields,
                dir_rows[i].want, produced);

    // random rounds; each one ends with the sequencer idle
    for (int rnd = 0; rnd < 4; rnd++) begin
      case (rnd)
        1: begin
          wait_drained();
          program_ctrl(8'h00, 8'hFF);
          snd_idle_pct = 63;
          rcv_idle_pct = 7;
        end
        2: begin
          wait_drained();
          program_ctrl(8'hFF, 8'h00);
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
        3: begin
          wait_drained();
          program_ctrl(8'($urandom), 8'($urandom));
        end
        default: ;
      endcase
      done_cnt = 0;
      beat_idx = 0;
      while (done_cnt < ROUND_BEATS || ph != ST_IDLE) begin
        // stall the receiver for a long stretch while beats keep coming
        if (rnd == 0 && beat_idx == 120) hold_req_cnt++;
        // pause the sender until every command beat is back
        if (rnd == 1 && beat_idx == 150) wait_drained();
        b = next_beat();
        send_beat(b, 1'b0, 1'b0, '0, produced);
        if (produced) done_cnt++;
        beat_idx++;
      end
    end

    wait_drained();
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
